// File: hw/rtl/rfo_pkg.sv
// Shared constants and types for the ring FIFO with overwrite.
`timescale 1ns / 1ps
`default_nettype none

package rfo_pkg;

    // Fixed field widths of the stream words.
    localparam int MODE_W  = 2;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;
    localparam int CAP_W   = 5;

    // Operation codes carried in s_tuser.
    localparam logic [MODE_W-1:0] OP_ENQ   = 2'd0;
    localparam logic [MODE_W-1:0] OP_DEQ   = 2'd1;
    localparam logic [MODE_W-1:0] OP_QUERY = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_OVERWRITE_MODE = 1'b0;
    localparam logic CFG_CAPACITY       = 1'b1;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic shift;
        logic load;
    } rfo_cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/rfo_cell.sv
// One storage cell of the FIFO chain: loads a new word or takes its neighbor's word.
`timescale 1ns / 1ps
`default_nettype none

module rfo_cell #(
    parameter int WORD_BITS = 32
) (
    input  wire                         clk,
    input  rfo_pkg::rfo_cell_ctrl_t     ctrl,
    input  wire [WORD_BITS-1:0]         load_data,
    input  wire [WORD_BITS-1:0]         shift_data,
    output logic [WORD_BITS-1:0]        data
);
    import rfo_pkg::*;

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;

    // A load wins over a shift so the newest word can enter the tail cell
    // in the same cycle as the chain moves up on an eviction.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = shift_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ring_fifo_with_overwrite_core.sv
// Top level of the ring FIFO with overwrite: control, cell chain and result register.
//
// Usage: operations arrive on the s_ stream; s_tuser selects enqueue, dequeue
// or occupancy query and s_tdata carries the word to enqueue. Every operation
// gives exactly one result word on the m_ stream: status and eviction flag in
// m_tuser, dequeued word, evicted word and occupancy in m_tdata.
// The queue is a chain of cells, the head cell holding the oldest word. A
// dequeue or an eviction moves the whole chain up by one cell, while an
// enqueue loads the cell at the fill count (or the last cell in use when the
// full ring evicts). Each operation is done in the cycle it is accepted; its
// result is valid in the output register from the next cycle on. One operation
// per cycle is sustained while m_tready is high. When the receiver stalls, the
// result waits and s_tready drops until it is taken. Reset empties the queue,
// selects fixed mode and a capacity of 16 (limited to DEPTH). Writing the
// capacity register clamps it to 1..DEPTH and empties the queue; the user must
// use the configuration port only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module ring_fifo_with_overwrite_core #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  wire                             clk,
    input  wire                             rst_n,
    // Configuration write port.
    input  wire                             cfg_we,
    input  wire                             cfg_index,
    input  wire [rfo_pkg::CAP_W-1:0]        cfg_data,
    // Operation stream.
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire [31:0]                      s_tdata,  // [31:0] entry_value
    input  wire [1:0]                       s_tuser,  // [1:0] mode
    // Result stream.
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // [31:0] entry_out, [63:32] evicted_value, [68:64] occupancy, [71:69] zero
    output logic [71:0]                     m_tdata,
    // [1:0] status, [2] evicted_valid
    output logic [2:0]                      m_tuser
);
    import rfo_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'((16 > DEPTH) ? DEPTH : 16);

    logic                   overwrite_reg;
    logic [CNT_W-1:0]       cap_reg;
    logic [CNT_W-1:0]       cap_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic                   out_valid_reg;
    logic [STAT_W-1:0]      status_reg;
    logic [STAT_W-1:0]      status_next;
    logic [VALUE_W-1:0]     entry_out_reg;
    logic [VALUE_W-1:0]     entry_out_next;
    logic                   ev_valid_reg;
    logic                   ev_valid_next;
    logic [VALUE_W-1:0]     ev_value_reg;
    logic [VALUE_W-1:0]     ev_value_next;
    logic [OCC_W-1:0]       occ_reg;

    logic                   accept;
    logic                   full;
    logic                   do_shift;
    logic                   load_at_count;
    logic                   load_at_tail;
    logic [WORD_BITS-1:0]   in_word;
    logic [WORD_BITS-1:0]   cell_data [DEPTH];
    rfo_cell_ctrl_t         cell_ctrl [DEPTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg >= cap_reg);
    assign in_word  = WORD_BITS'(s_tdata);

    // Clamp a capacity write into 1..DEPTH.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_next = CNT_W'(1);
        end
        else if (int'(cfg_data) > DEPTH)
        begin
            cap_next = CNT_W'(DEPTH);
        end
        else
        begin
            cap_next = CNT_W'(cfg_data);
        end
    end

    // Operation decode.
    always_comb
    begin
        count_next     = count_reg;
        status_next    = ST_OK;
        entry_out_next = '0;
        ev_valid_next  = 1'b0;
        ev_value_next  = '0;
        do_shift       = 1'b0;
        load_at_count  = 1'b0;
        load_at_tail   = 1'b0;
        if (accept)
        begin
            case (s_tuser)
                OP_ENQ:
                begin
                    if (!full)
                    begin
                        load_at_count = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                    else if (!overwrite_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ev_valid_next = 1'b1;
                        ev_value_next = VALUE_W'(cell_data[0]);
                        do_shift      = 1'b1;
                        load_at_tail  = 1'b1;
                    end
                end
                OP_DEQ:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        entry_out_next = VALUE_W'(cell_data[0]);
                        do_shift       = 1'b1;
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    // Query and the unused code change nothing.
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // Cell chain: each cell takes its upper neighbor's word on a shift.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [WORD_BITS-1:0] upper;

            if (gi == DEPTH - 1)
            begin : g_last
                assign upper = '0;
            end
            else
            begin : g_mid
                assign upper = cell_data[gi+1];
            end

            assign cell_ctrl[gi].shift = do_shift;
            assign cell_ctrl[gi].load  =
                (load_at_count && (count_reg == CNT_W'(gi))) ||
                (load_at_tail && (cap_reg - CNT_W'(1) == CNT_W'(gi)));

            rfo_cell #(
                .WORD_BITS(WORD_BITS)
            ) u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[gi]),
                .load_data  (in_word),
                .shift_data (upper),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overwrite_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_OVERWRITE_MODE))
            begin
                overwrite_reg <= cfg_data[0];
            end
            if (cfg_we && (cfg_index == CFG_CAPACITY))
            begin
                cap_reg   <= cap_next;
                count_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            entry_out_reg <= entry_out_next;
            ev_valid_reg  <= ev_valid_next;
            ev_value_reg  <= ev_value_next;
            occ_reg       <= OCC_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, occ_reg, ev_value_reg, entry_out_reg};
    assign m_tuser  = {ev_valid_reg, status_reg};

    // The fill count never passes the capacity in use.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("fill count above capacity");

    // An eviction only happens on a successful enqueue into a full ring.
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |->
            (m_tuser[1:0] == ST_OK) && (m_tdata[68:64] == OCC_W'(cap_reg)))
        else $error("eviction reported without a full ring");

    // A dequeue from a nonempty queue lowers the count by one.
    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == OP_DEQ) && (count_reg != '0) && !cfg_we) |=>
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("dequeue did not lower the fill count");

    // A query leaves the fill count unchanged.
    a_query_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == OP_QUERY) && !cfg_we) |=> $stable(count_reg))
        else $error("query changed the fill count");

endmodule

`default_nettype wire
